/* rtl/ellcls_pkg.sv */
package ellcls_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int HALF_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_A_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_A_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_B_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_B_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_MAJOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_FOCAL = 3'd5;

  // One lane per focus
  localparam int NLANE  = 2;
  localparam int LANE_A = 0;
  localparam int LANE_B = 1;

  // Datapath widths
  localparam int DIFF_W   = COORD_W;
  localparam int SQR_W    = 2 * COORD_W;
  localparam int SUM_W    = SQR_W + 1;
  localparam int RAD_W    = SUM_W + (SUM_W % 2);
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int SQ_STEPS = ROOT_W;
  localparam int SQ_STG   = (SQ_STEPS + 1) / 2;
  localparam int DSUM_W   = ROOT_W + 1;
  localparam int DDIFF_W  = DSUM_W + 1;

  // Pipeline depth
  localparam int FRONT_STG  = 3;
  localparam int DECIDE_STG = 2;
  localparam int LATENCY    = FRONT_STG + SQ_STG + DECIDE_STG;

  // Tolerance selection, in sixteenths of a pixel
  localparam int MARGIN_LIM = 32;
  localparam int TOL_WIDE   = 16;
  localparam int TOL_NARROW = 5;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[DIFF_W-1:0] : d[DIFF_W-1:0];
  endfunction

  // One digit of the restoring square root: bring down a bit pair, try 4*root+1
  function automatic sq_step_t sqrt_step(input logic [REM_W-1:0]  rem,
                                         input logic [ROOT_W-1:0] root,
                                         input logic [1:0]        pair);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] dif;
    sq_step_t         res;
    cur   = {rem, pair};
    trial = {1'b0, root, 2'b01};
    dif   = cur - trial;
    if (cur >= trial) begin
      res.rem  = dif[REM_W-1:0];
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cur[REM_W-1:0];
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* rtl/ellipse_point_classifier_core.sv */
// Point-in-ellipse classifier. Takes one point per clock whenever busy is low
// and returns is_inside / is_on_outline for it, marked by a one-cycle
// out_valid strobe; results come out in request order and the receiver cannot
// hold them off. The pipeline has three stages for the focal differences,
// squares and sum, nine stages of the square root unit (two root digits per
// stage, one lane per focus) and two for the final add and compares. Busy is
// high while reset is applied and falls once reset is released.
// Write the focus and axis registers only when no request is in flight; the
// configuration port is always ready.
module ellipse_point_classifier_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ellcls_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [ellcls_pkg::COORD_W-1:0] in_point_y,
  output logic                              out_valid,
  output logic                              out_is_inside,
  output logic                              out_is_on_outline,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ellcls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ellcls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ellcls_pkg::*;

  logic                busy_r;
  logic [COORD_W-1:0]  foc_x_r [NLANE];
  logic [COORD_W-1:0]  foc_y_r [NLANE];
  logic [HALF_W-1:0]   half_major_r;
  logic [HALF_W-1:0]   half_focal_r;
  logic                wide_tol_r;
  logic signed [HALF_W:0] margin;

  logic                accept;
  logic                fr_vld;
  logic [RAD_W-1:0]    fr_rad [NLANE];
  logic                sq_vld;
  logic [ROOT_W-1:0]   sq_root [NLANE];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  assign margin = $signed({1'b0, half_major_r}) - $signed({1'b0, half_focal_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      foc_x_r[LANE_A] <= '0;
      foc_y_r[LANE_A] <= '0;
      foc_x_r[LANE_B] <= '0;
      foc_y_r[LANE_B] <= '0;
      half_major_r <= '0;
      half_focal_r <= '0;
      wide_tol_r   <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      // Tolerance choice is registered; the user must change it only while idle, the block does not enforce that
      wide_tol_r <= (margin > $signed((HALF_W+1)'(MARGIN_LIM)));
      if (cfg_valid) begin
        case (cfg_index)
          REG_FOCUS_A_X:  foc_x_r[LANE_A] <= cfg_data[COORD_W-1:0];
          REG_FOCUS_A_Y:  foc_y_r[LANE_A] <= cfg_data[COORD_W-1:0];
          REG_FOCUS_B_X:  foc_x_r[LANE_B] <= cfg_data[COORD_W-1:0];
          REG_FOCUS_B_Y:  foc_y_r[LANE_B] <= cfg_data[COORD_W-1:0];
          REG_HALF_MAJOR: half_major_r    <= cfg_data[HALF_W-1:0];
          REG_HALF_FOCAL: half_focal_r    <= cfg_data[HALF_W-1:0];
          default: begin
            // drop writes to unused indexes
          end
        endcase
      end
    end
  end

  ellcls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .pt_x    (in_point_x),
    .pt_y    (in_point_y),
    .foc_x   (foc_x_r),
    .foc_y   (foc_y_r),
    .out_vld (fr_vld),
    .out_rad (fr_rad)
  );

  ellcls_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_rad   (fr_rad),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  ellcls_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (sq_vld),
    .root       (sq_root),
    .half_major (half_major_r),
    .wide_tol   (wide_tol_r),
    .out_vld    (out_valid),
    .is_in      (out_is_inside),
    .on_outline (out_is_on_outline)
  );

  // Every result traces back to an accepted request
  a_out_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  // Square root stage output lines up with its front stage input
  a_sqrt_from_front: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld |-> $past(fr_vld, SQ_STG))
    else $error("square root result without a front stage item");

  // Busy falls in the cycle after reset is released and stays low
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

endmodule

/* rtl/ellcls_front.sv */
module ellcls_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [ellcls_pkg::COORD_W-1:0] pt_x,
  input  logic [ellcls_pkg::COORD_W-1:0] pt_y,
  input  logic [ellcls_pkg::COORD_W-1:0] foc_x [ellcls_pkg::NLANE],
  input  logic [ellcls_pkg::COORD_W-1:0] foc_y [ellcls_pkg::NLANE],
  output logic                           out_vld,
  output logic [ellcls_pkg::RAD_W-1:0]   out_rad [ellcls_pkg::NLANE]
);
  import ellcls_pkg::*;

  logic              v1_r;
  logic              v2_r;
  logic              v3_r;
  logic [DIFF_W-1:0] dx_r  [NLANE];
  logic [DIFF_W-1:0] dy_r  [NLANE];
  logic [SQR_W-1:0]  sqx_r [NLANE];
  logic [SQR_W-1:0]  sqy_r [NLANE];
  logic [RAD_W-1:0]  rad_r [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    for (int l = 0; l < NLANE; l++) begin
      dx_r[l]  <= abs_diff(pt_x, foc_x[l]);
      dy_r[l]  <= abs_diff(pt_y, foc_y[l]);
      sqx_r[l] <= SQR_W'(dx_r[l]) * SQR_W'(dx_r[l]);
      sqy_r[l] <= SQR_W'(dy_r[l]) * SQR_W'(dy_r[l]);
      rad_r[l] <= RAD_W'(sqx_r[l]) + RAD_W'(sqy_r[l]);
    end
  end

  assign out_vld = v3_r;
  assign out_rad = rad_r;

endmodule

/* rtl/ellcls_sqrt_pipe.sv */
module ellcls_sqrt_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [ellcls_pkg::RAD_W-1:0]  in_rad   [ellcls_pkg::NLANE],
  output logic                          out_vld,
  output logic [ellcls_pkg::ROOT_W-1:0] out_root [ellcls_pkg::NLANE]
);
  import ellcls_pkg::*;

  logic [SQ_STG:0]   vld_c;
  logic [RAD_W-1:0]  rad_c  [SQ_STG+1][NLANE];
  logic [REM_W-1:0]  rem_c  [SQ_STG+1][NLANE];
  logic [ROOT_W-1:0] root_c [SQ_STG+1][NLANE];

  assign vld_c[0] = in_vld;

  for (genvar l = 0; l < NLANE; l++) begin : g_in
    assign rad_c[0][l]  = in_rad[l];
    assign rem_c[0][l]  = '0;
    assign root_c[0][l] = '0;
  end

  // Two root digits per stage, the last stage takes the odd one
  for (genvar s = 0; s < SQ_STG; s++) begin : g_stg
    logic             vld_r;
    logic [RAD_W-1:0] rad_r   [NLANE];
    sq_step_t         res_r   [NLANE];
    sq_step_t         mid     [NLANE];
    sq_step_t         res_nxt [NLANE];

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      assign mid[l] = sqrt_step(rem_c[s][l], root_c[s][l],
                                rad_c[s][l][RAD_W-1-4*s -: 2]);
      if (2 * s + 1 < SQ_STEPS) begin : g_two
        assign res_nxt[l] = sqrt_step(mid[l].rem, mid[l].root,
                                      rad_c[s][l][RAD_W-3-4*s -: 2]);
      end else begin : g_one
        assign res_nxt[l] = mid[l];
      end
      assign rad_c[s+1][l]  = rad_r[l];
      assign rem_c[s+1][l]  = res_r[l].rem;
      assign root_c[s+1][l] = res_r[l].root;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_c[s];
      end
      rad_r <= rad_c[s];
      res_r <= res_nxt;
    end

    assign vld_c[s+1] = vld_r;
  end

  assign out_vld  = vld_c[SQ_STG];
  assign out_root = root_c[SQ_STG];

endmodule

/* rtl/ellcls_decide.sv */
module ellcls_decide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [ellcls_pkg::ROOT_W-1:0] root [ellcls_pkg::NLANE],
  input  logic [ellcls_pkg::HALF_W-1:0] half_major,
  input  logic                          wide_tol,
  output logic                          out_vld,
  output logic                          is_in,
  output logic                          on_outline
);
  import ellcls_pkg::*;

  logic                      v1_r;
  logic                      v2_r;
  logic signed [DDIFF_W-1:0] diff_r;
  logic signed [DDIFF_W-1:0] diff_nxt;
  logic signed [DDIFF_W-1:0] tol;
  logic                      inside_r;
  logic                      on_r;

  // Sum of the two focal distances minus twice the half major axis
  assign diff_nxt = $signed(DDIFF_W'(root[LANE_A]) + DDIFF_W'(root[LANE_B])
                            - DDIFF_W'({half_major, 1'b0}));

  assign tol = wide_tol ? DDIFF_W'(TOL_WIDE) : DDIFF_W'(TOL_NARROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
    diff_r   <= diff_nxt;
    inside_r <= (diff_r <= $signed(DDIFF_W'(0)));
    on_r     <= (diff_r < tol) && (diff_r > -tol);
  end

  assign out_vld    = v2_r;
  assign is_in      = inside_r;
  assign on_outline = on_r;

endmodule

/* tb/ellipse_point_classifier_core_test.sv */
`timescale 1ns / 100ps

module ellipse_point_classifier_core_test;
  import ellcls_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_POINTS = 850;
  localparam int REPORT_MAX    = 50;

  // Indexes past the last register; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic in_ell;
    logic outline;
  } verdict_t;

  typedef enum logic { ROW_REG, ROW_POINT } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic                       known;
    verdict_t                   want;
  } plan_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [COORD_W-1:0]   in_point_x;
  logic signed [COORD_W-1:0]   in_point_y;
  logic                        out_valid;
  logic                        out_is_inside;
  logic                        out_is_on_outline;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  ellipse_point_classifier_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .out_valid         (out_valid),
    .out_is_inside     (out_is_inside),
    .out_is_on_outline (out_is_on_outline),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Shadow copy of the ellipse registers
  logic signed [COORD_W-1:0] foc_ax = '0;
  logic signed [COORD_W-1:0] foc_ay = '0;
  logic signed [COORD_W-1:0] foc_bx = '0;
  logic signed [COORD_W-1:0] foc_by = '0;
  logic [HALF_W-1:0]         half_major_q = '0;
  logic [HALF_W-1:0]         half_focal_q = '0;

  verdict_t pending_verdicts[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  logic     drv_known = 1'b0;
  verdict_t drv_want = '0;
  longint   ctr_x = 0;
  longint   ctr_y = 0;
  longint   reach = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned bitv;
    rest = v;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rest) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - root - bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned focus_range(input logic signed [COORD_W-1:0] px, py,
                                                  input logic signed [COORD_W-1:0] fx, fy);
    longint dx;
    longint dy;
    dx = longint'(px) - longint'(fx);
    dy = longint'(py) - longint'(fy);
    return floor_root(longint'(dx * dx + dy * dy));
  endfunction

  function automatic verdict_t classify_point(input logic signed [COORD_W-1:0] px, py);
    longint   span;
    longint   twice;
    longint   margin;
    longint   gap;
    verdict_t v;
    span   = focus_range(px, py, foc_ax, foc_ay) + focus_range(px, py, foc_bx, foc_by);
    twice  = 2 * longint'(half_major_q);
    margin = longint'(half_major_q) - longint'(half_focal_q);
    gap    = span - twice;
    if (gap < 0) gap = -gap;
    v.in_ell  = span <= twice;
    v.outline = gap < ((margin > MARGIN_LIM) ? TOL_WIDE : TOL_NARROW);
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint ray_coord(input longint base, dir, t);
    return base + dir * t / 1024;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t point_row(input logic signed [COORD_W-1:0] px, py);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_POINT;
    r.px   = px;
    r.py   = py;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic signed [COORD_W-1:0] px, py,
                                          input logic want_in, outline);
    plan_row_t r;
    r              = point_row(px, py);
    r.known        = 1'b1;
    r.want.in_ell  = want_in;
    r.want.outline = outline;
    return r;
  endfunction

  // Issue one point request; the sender runs in bursts with gaps between them
  task automatic send_point(input logic signed [COORD_W-1:0] px, py,
                            input logic known, input verdict_t want);
    if (burst_left == 0) begin
      start      = 1'b0;
      in_point_x = COORD_W'($urandom);
      in_point_y = COORD_W'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    end
    burst_left--;
    start      = 1'b1;
    in_point_x = px;
    in_point_y = py;
    drv_known  = known;
    drv_want   = want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start and hold until every outstanding request has returned
  task automatic wait_idle();
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOCUS_A_X:  foc_ax = cfg_data;
          REG_FOCUS_A_Y:  foc_ay = cfg_data;
          REG_FOCUS_B_X:  foc_bx = cfg_data;
          REG_FOCUS_B_Y:  foc_by = cfg_data;
          REG_HALF_MAJOR: half_major_q = cfg_data[HALF_W-1:0];
          REG_HALF_FOCAL: half_focal_q = cfg_data[HALF_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        pending_verdicts.push_back(drv_known ? drv_want : classify_point(in_point_x, in_point_y));
      if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("%0t: result with no request outstanding, expected none, got inside %0b outline %0b",
                     $time, out_is_inside, out_is_on_outline);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_is_inside !== want.in_ell) begin
            if (mismatch_count < REPORT_MAX)
              $display("%0t: is_inside mismatch, expected %0b, got %0b",
                       $time, want.in_ell, out_is_inside);
            mismatch_count++;
          end
          if (out_is_on_outline !== want.outline) begin
            if (mismatch_count < REPORT_MAX)
              $display("%0t: is_on_outline mismatch, expected %0b, got %0b",
                       $time, want.outline, out_is_on_outline);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    plan_row_t                 plan[$];
    verdict_t                  probe;
    logic signed [COORD_W-1:0] ax, ay, bx, by, qx, qy;
    logic [CFG_DATA_W-1:0]     hmaj_w, hfoc_w;
    longint                    fvx, fvy, c_len, dir_x, dir_y, lo, hi, mid, span_max;
    int                        style, n_items, pick, random_sent;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // All registers are zero after reset: both foci at the origin, narrow tolerance
    plan.push_back(known_row(0, 0, 1'b1, 1'b1));
    plan.push_back(known_row(2, 0, 1'b0, 1'b1));
    plan.push_back(known_row(3, 0, 1'b0, 1'b0));
    plan.push_back(known_row(32767, 32767, 1'b0, 1'b0));
    plan.push_back(known_row(-32768, -32768, 1'b0, 1'b0));
    plan.push_back(known_row(-32768, 32767, 1'b0, 1'b0));
    plan.push_back(reg_row(REG_SPARE_6, 16'hFFFF));
    plan.push_back(reg_row(REG_SPARE_7, 16'hFFFF));
    plan.push_back(known_row(1, 0, 1'b0, 1'b1));
    // Wide ellipse, foci 10 pixels either side of the origin
    plan.push_back(reg_row(REG_FOCUS_A_X, CFG_DATA_W'(-160)));
    plan.push_back(reg_row(REG_FOCUS_A_Y, 0));
    plan.push_back(reg_row(REG_FOCUS_B_X, 160));
    plan.push_back(reg_row(REG_FOCUS_B_Y, 0));
    plan.push_back(reg_row(REG_HALF_MAJOR, 320));
    plan.push_back(reg_row(REG_HALF_FOCAL, 160));
    plan.push_back(point_row(0, 0));
    plan.push_back(point_row(320, 0));
    plan.push_back(point_row(327, 0));
    plan.push_back(point_row(328, 0));
    plan.push_back(point_row(336, 0));
    plan.push_back(point_row(0, 277));
    plan.push_back(point_row(0, COORD_W'(-300)));
    // Margin of exactly two pixels still takes the narrow tolerance
    plan.push_back(reg_row(REG_HALF_FOCAL, 288));
    plan.push_back(point_row(320, 0));
    plan.push_back(point_row(322, 0));
    plan.push_back(point_row(324, 0));
    plan.push_back(reg_row(REG_HALF_FOCAL, 287));
    plan.push_back(point_row(324, 0));
    // Focal distance beyond the major axis
    plan.push_back(reg_row(REG_HALF_FOCAL, 16'hFFFF));
    plan.push_back(point_row(324, 0));
    // Foci in opposite corners, largest axis
    plan.push_back(reg_row(REG_FOCUS_A_X, 16'h8000));
    plan.push_back(reg_row(REG_FOCUS_A_Y, 16'h8000));
    plan.push_back(reg_row(REG_FOCUS_B_X, 16'h7FFF));
    plan.push_back(reg_row(REG_FOCUS_B_Y, 16'h7FFF));
    plan.push_back(reg_row(REG_HALF_MAJOR, 16'hFFFF));
    plan.push_back(point_row(16'sh8000, 16'sh8000));
    plan.push_back(point_row(32767, 16'sh8000));
    plan.push_back(point_row(0, 0));
    plan.push_back(point_row(16'sh8000, 32767));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_point(plan[i].px, plan[i].py, plan[i].known, plan[i].want);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_POINTS) begin
      style = $urandom_range(0, 9);
      if (style == 0) begin
        ax     = COORD_W'($urandom);
        ay     = COORD_W'($urandom);
        bx     = COORD_W'($urandom);
        by     = COORD_W'($urandom);
        hmaj_w = CFG_DATA_W'($urandom);
        hfoc_w = CFG_DATA_W'($urandom);
      end else if (style == 1) begin
        ax     = pick_extreme();
        ay     = pick_extreme();
        bx     = pick_extreme();
        by     = pick_extreme();
        hmaj_w = $urandom_range(0, 1) ? 16'hFFFF : ($urandom_range(0, 1) ? 16'h0000 : 16'($urandom));
        hfoc_w = $urandom_range(0, 1) ? 16'hFFFF : ($urandom_range(0, 1) ? 16'h0000 : 16'($urandom));
      end else begin
        ctr_x = longint'($urandom_range(0, 16000)) - 8000;
        ctr_y = longint'($urandom_range(0, 16000)) - 8000;
        if ($urandom_range(0, 3) == 0) begin
          fvx = longint'($urandom_range(0, 40)) - 20;
          fvy = longint'($urandom_range(0, 40)) - 20;
        end else begin
          fvx = longint'($urandom_range(0, 2800)) - 1400;
          fvy = longint'($urandom_range(0, 2800)) - 1400;
        end
        ax    = clamp_coord(ctr_x + fvx);
        ay    = clamp_coord(ctr_y + fvy);
        bx    = clamp_coord(ctr_x - fvx);
        by    = clamp_coord(ctr_y - fvy);
        c_len = floor_root(fvx * fvx + fvy * fvy);
        // Spread the axis margin around the tolerance switch point
        case ($urandom_range(0, 3))
          0: reach = c_len + $urandom_range(28, 36);
          1: reach = c_len + $urandom_range(0, 64);
          2: reach = c_len + $urandom_range(64, 3000);
          default: begin
            reach = c_len - $urandom_range(1, 40);
            if (reach < 0) reach = 0;
          end
        endcase
        hmaj_w = CFG_DATA_W'(reach);
        hfoc_w = CFG_DATA_W'(c_len);
      end

      wait_idle();
      write_reg(REG_FOCUS_A_X, ax);
      write_reg(REG_FOCUS_A_Y, ay);
      write_reg(REG_FOCUS_B_X, bx);
      write_reg(REG_FOCUS_B_Y, by);
      write_reg(REG_HALF_MAJOR, hmaj_w);
      write_reg(REG_HALF_FOCAL, hfoc_w);
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W'($urandom));

      n_items = $urandom_range(20, 60);
      repeat (n_items) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          qx = COORD_W'($urandom);
          qy = COORD_W'($urandom);
        end else if (style < 2) begin
          // Scatter around one of the foci
          if (pick < 5) begin
            qx = clamp_coord(longint'(ax) + longint'($urandom_range(0, 4096)) - 2048);
            qy = clamp_coord(longint'(ay) + longint'($urandom_range(0, 4096)) - 2048);
          end else begin
            qx = clamp_coord(longint'(bx) + longint'($urandom_range(0, 4096)) - 2048);
            qy = clamp_coord(longint'(by) + longint'($urandom_range(0, 4096)) - 2048);
          end
        end else if (pick < 7) begin
          // Bisect along a random ray from the center to land near the outline
          do begin
            dir_x = longint'($urandom_range(0, 2048)) - 1024;
            dir_y = longint'($urandom_range(0, 2048)) - 1024;
          end while (dir_x == 0 && dir_y == 0);
          span_max = (dir_x < 0) ? -dir_x : dir_x;
          if (dir_y > span_max) span_max = dir_y;
          if (-dir_y > span_max) span_max = -dir_y;
          lo = 0;
          hi = (3 * reach + 64) * 1024 / span_max;
          repeat (24) begin
            mid   = (lo + hi) / 2;
            probe = classify_point(clamp_coord(ray_coord(ctr_x, dir_x, mid)),
                                   clamp_coord(ray_coord(ctr_y, dir_y, mid)));
            if (probe.in_ell) lo = mid;
            else hi = mid;
          end
          qx = clamp_coord(ray_coord(ctr_x, dir_x, lo) + longint'($urandom_range(0, 48)) - 24);
          qy = clamp_coord(ray_coord(ctr_y, dir_y, lo) + longint'($urandom_range(0, 48)) - 24);
        end else begin
          qx = clamp_coord(ctr_x + longint'($urandom_range(0, 32'(2 * reach + 64))) - reach - 32);
          qy = clamp_coord(ctr_y + longint'($urandom_range(0, 32'(2 * reach + 64))) - reach - 32);
        end
        send_point(qx, qy, 1'b0, '0);
        random_sent++;
      end
    end

    wait_idle();
    repeat (LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
